>>> hw/rtl/ervd_pkg.sv
// ----------------------------------------------------------------------------
// ervd_pkg
// Shared widths, register indexes and types of the energy-ratio voice end
// detector.
// ----------------------------------------------------------------------------
package ervd_pkg;

  // sample path
  localparam int SAMPLE_W   = 16;
  localparam int FILT_W     = SAMPLE_W + 4;
  localparam int DIFF_W     = FILT_W + 2;
  localparam int ALPHA_W    = 16;
  localparam int PROD_W     = DIFF_W + ALPHA_W + 1;
  localparam int ROUND_SH   = 16;
  localparam int MAG_W      = FILT_W;

  // accumulators and counters
  localparam int TOTAL_W    = 36;
  localparam int WSUM_W     = 34;
  localparam int CNT_W      = 17;
  localparam int MAX_BUFFER = 65536;
  localparam int MAX_WINDOW = 16384;
  localparam int RING_AW    = $clog2(MAX_WINDOW);
  localparam int WIN_W      = 15;
  localparam int RATIO_W    = 16;
  localparam int RATIO_SH   = 14;

  // ratio test datapath
  localparam int SPLIT_A    = 17;
  localparam int SPLIT_B    = 18;
  localparam int MUL_A_W    = 18;
  localparam int MUL_B_W    = RATIO_W + WIN_W;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_A_W    = WSUM_W + CNT_W;
  localparam int ACC_B_W    = TOTAL_W + MUL_B_W;

  // stream and configuration port
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 96;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = 16;

  localparam logic [CFG_AW-1:0] REG_FILTER_ENABLE = 2'd0;
  localparam logic [CFG_AW-1:0] REG_FILTER_ALPHA  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_WINDOW_LENGTH = 2'd2;
  localparam logic [CFG_AW-1:0] REG_ENERGY_RATIO  = 2'd3;

  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 16'd58982;
  localparam logic [WIN_W-1:0]   WINDOW_RST = 15'd16000;
  localparam logic [RATIO_W-1:0] RATIO_RST  = 16'd9830;

  // request to the ratio test unit
  typedef struct packed {
    logic                 start;
    logic [WSUM_W-1:0]    wsum;
    logic [CNT_W-1:0]     count;
    logic [TOTAL_W-1:0]   total;
    logic [RATIO_W-1:0]   ratio;
    logic [WIN_W-1:0]     window;
  } cmp_req_t;

  typedef struct packed {
    logic done;
    logic ended;
  } cmp_rsp_t;

endpackage

>>> hw/rtl/ervd_ram.sv
// ----------------------------------------------------------------------------
// ervd_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ervd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/ervd_ratio_cmp.sv
// ----------------------------------------------------------------------------
// ervd_ratio_cmp
// Multi-cycle test recent*count*2^14 <= ratio*total*window on one shared
// 18x31 multiplier.
// ----------------------------------------------------------------------------
module ervd_ratio_cmp
  import ervd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cmp_req_t req,
  output cmp_rsp_t rsp
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_RW, PH_A_LO, PH_A_HI, PH_B_LO, PH_B_HI, PH_B_ACC, PH_CMP
  } ph_t;

  ph_t                ph_r;
  logic               done_r;
  logic               ended_r;
  logic [WSUM_W-1:0]  wsum_r;
  logic [CNT_W-1:0]   count_r;
  logic [TOTAL_W-1:0] total_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [WIN_W-1:0]   window_r;
  logic [MUL_B_W-1:0] rw_r;
  logic [MUL_P_W-1:0] prod_r;
  logic [ACC_A_W-1:0] acc_a_r;
  logic [ACC_B_W-1:0] acc_b_r;

  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod_nxt;
  logic [ACC_B_W-1:0] lhs;

  // operand select per phase
  always_comb begin
    case (ph_r)
      PH_RW: begin
        mul_a = MUL_A_W'(ratio_r);
        mul_b = MUL_B_W'(window_r);
      end
      PH_A_LO: begin
        mul_a = MUL_A_W'(wsum_r[SPLIT_A-1:0]);
        mul_b = MUL_B_W'(count_r);
      end
      PH_A_HI: begin
        mul_a = MUL_A_W'(wsum_r[WSUM_W-1:SPLIT_A]);
        mul_b = MUL_B_W'(count_r);
      end
      PH_B_LO: begin
        mul_a = MUL_A_W'(total_r[SPLIT_B-1:0]);
        mul_b = rw_r;
      end
      PH_B_HI: begin
        mul_a = MUL_A_W'(total_r[TOTAL_W-1:SPLIT_B]);
        mul_b = rw_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  assign lhs      = ACC_B_W'({acc_a_r, {RATIO_SH{1'b0}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      case (ph_r)
        PH_IDLE: begin
          if (req.start) begin
            wsum_r   <= req.wsum;
            count_r  <= req.count;
            total_r  <= req.total;
            ratio_r  <= req.ratio;
            window_r <= req.window;
            done_r   <= 1'b0;
            ph_r     <= PH_RW;
          end
        end
        PH_RW: begin
          prod_r <= prod_nxt;
          ph_r   <= PH_A_LO;
        end
        PH_A_LO: begin
          rw_r   <= prod_r[MUL_B_W-1:0];
          prod_r <= prod_nxt;
          ph_r   <= PH_A_HI;
        end
        PH_A_HI: begin
          acc_a_r <= ACC_A_W'(prod_r);
          prod_r  <= prod_nxt;
          ph_r    <= PH_B_LO;
        end
        PH_B_LO: begin
          acc_a_r <= acc_a_r + ACC_A_W'({prod_r, {SPLIT_A{1'b0}}});
          prod_r  <= prod_nxt;
          ph_r    <= PH_B_HI;
        end
        PH_B_HI: begin
          acc_b_r <= ACC_B_W'(prod_r);
          prod_r  <= prod_nxt;
          ph_r    <= PH_B_ACC;
        end
        PH_B_ACC: begin
          acc_b_r <= acc_b_r + ACC_B_W'({prod_r, {SPLIT_B{1'b0}}});
          ph_r    <= PH_CMP;
        end
        PH_CMP: begin
          ended_r <= (lhs <= acc_b_r);
          done_r  <= 1'b1;
          ph_r    <= PH_IDLE;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.ended = ended_r;

endmodule

>>> hw/rtl/energy_ratio_voice_end_detector.sv
// ----------------------------------------------------------------------------
// energy_ratio_voice_end_detector
// Per-buffer energy ratio test that flags the end of speech in a PCM stream.
// ----------------------------------------------------------------------------
// Samples arrive one per request on the in_ stream, in_tlast marking the last
// sample of a buffer. Each sample optionally goes through a first-order
// high-pass filter (the first sample of a buffer passes raw), its magnitude is
// added to a saturating buffer total and to a sliding sum over the trailing
// window, and is written to a 16384-entry magnitude ring held in one RAM.
// The accept cycle reads the ring entry leaving the window and registers the
// filter product; the update state then does the rounding, saturation, sums
// and ring write. After the last sample of a buffer come the update, a state
// that hands the sums to the ratio test, seven ratio test steps (five products
// on one shared multiplier, an add and the compare) and the cycle that loads
// the result register; it waits longer if the result register still holds an
// untaken request.
// One result request is produced per buffer. The ring needs no clearing after
// reset: only entries written within the current buffer are used.
// ----------------------------------------------------------------------------
module energy_ratio_voice_end_detector
  import ervd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] sample
  input  logic                   in_tlast,   // last sample of the buffer
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] speech_done, [1] too_short,
                                             // [37:2] total_energy_sum,
                                             // [71:38] recent_energy_sum,
                                             // [88:72] buffer_count, rest zero
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_DW-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_UPD, S_START, S_CMP} state_t;

  state_t                    state_r;

  // configuration
  logic                      filt_en_r;
  logic [ALPHA_W-1:0]        alpha_r;
  logic [WIN_W-1:0]          window_r;
  logic [RATIO_W-1:0]        ratio_r;

  // per-buffer state
  logic signed [FILT_W-1:0]  y_r;
  logic signed [SAMPLE_W-1:0] xprev_r;
  logic [TOTAL_W-1:0]        total_r;
  logic [WSUM_W-1:0]         wsum_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [RING_AW-1:0]        ptr_r;

  // sample in flight
  logic signed [SAMPLE_W-1:0] x_r;
  logic                      last_r;
  logic                      use_filt_r;
  logic signed [PROD_W-1:0]  prod_r;

  // result register
  logic                      out_tvalid_r;
  logic [OUT_TDATA_W-1:0]    out_tdata_r;

  logic                      accept;
  logic [WIN_W-1:0]          w_eff;
  logic signed [SAMPLE_W-1:0] x_in;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [PROD_W-1:0]  rounded;
  logic signed [PROD_W-ROUND_SH-1:0] y_wide;
  logic signed [FILT_W-1:0]  y_filt;
  logic signed [FILT_W-1:0]  y_nxt;
  logic [MAG_W-1:0]          mag;
  logic [TOTAL_W:0]          total_add;
  logic [TOTAL_W-1:0]        total_nxt;
  logic [WSUM_W:0]           wsum_add;
  logic [WSUM_W:0]           old_mag;
  logic [WSUM_W:0]           wsum_sub;
  logic [WSUM_W-1:0]         wsum_nxt;
  logic [CNT_W-1:0]          cnt_nxt;
  logic                      drop_old;
  logic                      short_buf;
  logic                      out_load;
  logic [MAG_W-1:0]          ring_rd_data;
  logic [RING_AW-1:0]        ring_rd_addr;
  cmp_req_t                  cmp_req;
  cmp_rsp_t                  cmp_rsp;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid & in_tready;

  // window clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (window_r > WIN_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = window_r;
    end
  end

  // filter front half: difference and product, registered at accept
  assign x_in     = $signed(in_tdata[SAMPLE_W-1:0]);
  assign diff     = DIFF_W'(y_r) + DIFF_W'(x_in) - DIFF_W'(xprev_r);
  assign prod_nxt = PROD_W'(diff) * PROD_W'($signed({1'b0, alpha_r}));

  // filter back half: round to nearest, then saturate to FILT_W bits
  assign rounded = prod_r + PROD_W'(1 << (ROUND_SH - 1));
  assign y_wide  = rounded[PROD_W-1:ROUND_SH];

  always_comb begin
    if (y_wide[PROD_W-ROUND_SH-1:FILT_W-1] == '0 ||
        y_wide[PROD_W-ROUND_SH-1:FILT_W-1] == '1) begin
      y_filt = y_wide[FILT_W-1:0];
    end else if (y_wide[PROD_W-ROUND_SH-1]) begin
      y_filt = {1'b1, {(FILT_W-1){1'b0}}};
    end else begin
      y_filt = {1'b0, {(FILT_W-1){1'b1}}};
    end
  end

  // first sample of a buffer and disabled filter both pass the raw sample
  assign y_nxt = use_filt_r ? y_filt : FILT_W'(x_r);
  assign mag   = y_nxt[FILT_W-1] ? (~y_nxt + MAG_W'(1)) : y_nxt;

  // saturating buffer total
  assign total_add = {1'b0, total_r} + (TOTAL_W+1)'(mag);
  assign total_nxt = total_add[TOTAL_W] ? '1 : total_add[TOTAL_W-1:0];

  // sliding window sum, oldest magnitude leaves once the window is full
  assign drop_old = (cnt_r >= CNT_W'(w_eff));
  assign wsum_add = {1'b0, wsum_r} + (WSUM_W+1)'(mag);
  assign old_mag  = (WSUM_W+1)'(ring_rd_data);

  always_comb begin
    if (!drop_old) begin
      wsum_sub = wsum_add;
    end else if (wsum_add >= old_mag) begin
      wsum_sub = wsum_add - old_mag;
    end else begin
      wsum_sub = '0;
    end
  end

  assign wsum_nxt = wsum_sub[WSUM_W-1:0];
  assign cnt_nxt  = (cnt_r < CNT_W'(MAX_BUFFER)) ? cnt_r + CNT_W'(1) : cnt_r;

  // ring entry leaving the window sits w_eff writes behind the pointer
  assign ring_rd_addr = ptr_r - w_eff[RING_AW-1:0];

  ervd_ram #(
    .WIDTH (MAG_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == S_UPD),
    .wr_addr (ptr_r),
    .wr_data (mag),
    .rd_en   (accept),
    .rd_addr (ring_rd_addr),
    .rd_data (ring_rd_data)
  );

  // ratio test on the finished buffer
  assign cmp_req.start  = (state_r == S_START);
  assign cmp_req.wsum   = wsum_r;
  assign cmp_req.count  = cnt_r;
  assign cmp_req.total  = total_r;
  assign cmp_req.ratio  = ratio_r;
  assign cmp_req.window = w_eff;

  ervd_ratio_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cmp_req),
    .rsp   (cmp_rsp)
  );

  assign short_buf = (cnt_r <= CNT_W'(w_eff));
  assign out_load  = (state_r == S_CMP) && cmp_rsp.done &&
                     (!out_tvalid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      filt_en_r    <= 1'b1;
      alpha_r      <= ALPHA_RST;
      window_r     <= WINDOW_RST;
      ratio_r      <= RATIO_RST;
      y_r          <= '0;
      xprev_r      <= '0;
      total_r      <= '0;
      wsum_r       <= '0;
      cnt_r        <= '0;
      ptr_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_FILTER_ENABLE: filt_en_r <= cfg_wdata[0];
          REG_FILTER_ALPHA:  alpha_r   <= cfg_wdata[ALPHA_W-1:0];
          REG_WINDOW_LENGTH: window_r  <= cfg_wdata[WIN_W-1:0];
          REG_ENERGY_RATIO:  ratio_r   <= cfg_wdata[RATIO_W-1:0];
          default: ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r        <= x_in;
            last_r     <= in_tlast;
            use_filt_r <= filt_en_r && (cnt_r != '0);
            prod_r     <= prod_nxt;
            state_r    <= S_UPD;
          end
        end
        S_UPD: begin
          y_r     <= y_nxt;
          xprev_r <= x_r;
          total_r <= total_nxt;
          wsum_r  <= wsum_nxt;
          cnt_r   <= cnt_nxt;
          ptr_r   <= ptr_r + RING_AW'(1);
          state_r <= last_r ? S_START : S_IDLE;
        end
        S_START: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (out_load) begin
            // buffer done, open a fresh one
            y_r     <= '0;
            xprev_r <= '0;
            total_r <= '0;
            wsum_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase

      // result register
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= OUT_TDATA_W'({cnt_r, wsum_r, total_r, short_buf,
                                      !short_buf && cmp_rsp.ended});
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // the window sum is a part of the buffer total
  a_wsum_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    {{(TOTAL_W-WSUM_W){1'b0}}, wsum_r} <= total_r)
    else $error("window sum above buffer total");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BUFFER))
    else $error("sample count beyond saturation");

  a_short_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !(out_tdata_r[1] && out_tdata_r[0]))
    else $error("short buffer flagged as speech ended");

endmodule
